@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros shared by the allocator RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every rising edge outside reset.
`define SFLA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An implication that must hold at every rising edge outside reset.
`define SFLA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ hdl/sfla_pkg.sv @@
// ===========================================================================
// sfla_pkg
// Types and constants shared by the slot free-list allocator modules.
// ===========================================================================
`timescale 1ns / 1ps
`default_nettype none

package sfla_pkg;

    // Pool geometry; the slot fields are fixed at ten bits.
    localparam int SLOTS  = 1024;
    localparam int SLOT_W = 10;
    localparam int CNT_W  = 11;

    // Request operations.
    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Response status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_EMPTY    = 2'd1;
    localparam logic [1:0] ST_NOT_LIVE = 2'd2;

    // Request payload.
    typedef struct packed {
        logic [1:0]        op;
        logic [SLOT_W-1:0] slot_index;
    } t_req;

    // Response payload.
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [1:0]        status;
        logic [CNT_W-1:0]  high_water;
    } t_rsp;

    // Port commands for the free stack memory.
    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        logic [SLOT_W-1:0] wdata;
        logic [SLOT_W-1:0] raddr;
    } t_stk_port;

    // Port commands for the live map memory.
    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        logic              wdata;
        logic [SLOT_W-1:0] raddr;
    } t_live_port;

    // Controller status seen by the top level.
    typedef struct packed {
        logic [CNT_W-1:0] free_count;
        logic [CNT_W-1:0] high_water;
    } t_ctrl_stat;

endpackage

`default_nettype wire

@@ hdl/sfla_ram.sv @@
// ===========================================================================
// sfla_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ===========================================================================
`timescale 1ns / 1ps
`default_nettype none

module sfla_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ hdl/sfla_ctrl.sv @@
// ===========================================================================
// sfla_ctrl
// Sequencer for the allocator: pops and pushes the free stack, updates the
// live map and walks the high-water mark down after a free.
// ===========================================================================
`timescale 1ns / 1ps
`default_nettype none

module sfla_ctrl (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire sfla_pkg::t_req         i_in_req,
    input  wire logic                   i_out_free,
    output logic                        o_load,
    output sfla_pkg::t_rsp              o_res,
    output sfla_pkg::t_stk_port         o_stk,
    input  wire logic [sfla_pkg::SLOT_W-1:0] i_stk_rdata,
    output sfla_pkg::t_live_port        o_live,
    input  wire logic                   i_live_rdata,
    output sfla_pkg::t_ctrl_stat        o_stat
);

    localparam logic [2:0] S_SWEEP    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_ALLOC    = 3'd2;
    localparam logic [2:0] S_FCHK     = 3'd3;
    localparam logic [2:0] S_SCAN_RD  = 3'd4;
    localparam logic [2:0] S_SCAN_CHK = 3'd5;
    localparam logic [2:0] S_OUT      = 3'd6;

    localparam logic [sfla_pkg::SLOT_W-1:0] LAST_SLOT =
        sfla_pkg::SLOT_W'(sfla_pkg::SLOTS - 1);
    localparam logic [sfla_pkg::CNT_W-1:0] FULL_COUNT =
        sfla_pkg::CNT_W'(sfla_pkg::SLOTS);

    logic [2:0]                    r_state, n_state;
    logic [sfla_pkg::SLOT_W-1:0]   r_sweep, n_sweep;
    logic [sfla_pkg::CNT_W-1:0]    r_free_count, n_free_count;
    logic [sfla_pkg::CNT_W-1:0]    r_low, n_low;
    logic [sfla_pkg::CNT_W-1:0]    r_top, n_top;
    logic                          r_after_sweep, n_after_sweep;
    logic [sfla_pkg::SLOT_W-1:0]   r_idx, n_idx;
    sfla_pkg::t_rsp                r_res, n_res;

    logic [sfla_pkg::SLOT_W-1:0]   w_pop_pos;
    logic [sfla_pkg::SLOT_W-1:0]   w_pop_slot;
    logic [sfla_pkg::CNT_W-1:0]    w_slot_inc;
    logic [sfla_pkg::CNT_W-1:0]    w_top_dec;

    // Stack positions below the low mark were never written since the last
    // clear, so they still hold their initial slot numbers.
    assign w_pop_pos  = r_free_count[sfla_pkg::SLOT_W-1:0] - sfla_pkg::SLOT_W'(1);
    assign w_pop_slot = (r_free_count == r_low) ? (LAST_SLOT - w_pop_pos) : i_stk_rdata;
    assign w_slot_inc = {1'b0, w_pop_slot} + sfla_pkg::CNT_W'(1);
    assign w_top_dec  = r_top - sfla_pkg::CNT_W'(1);

    // Next-state logic.
    always_comb begin
        n_state       = r_state;
        n_sweep       = r_sweep;
        n_free_count  = r_free_count;
        n_low         = r_low;
        n_top         = r_top;
        n_after_sweep = r_after_sweep;
        n_idx         = r_idx;
        n_res         = r_res;
        o_load        = 1'b0;

        o_stk.we      = 1'b0;
        o_stk.waddr   = r_free_count[sfla_pkg::SLOT_W-1:0];
        o_stk.wdata   = r_idx;
        o_stk.raddr   = w_pop_pos;

        o_live.we     = 1'b0;
        o_live.waddr  = r_idx;
        o_live.wdata  = 1'b0;
        o_live.raddr  = i_in_req.slot_index;

        case (r_state)
            S_SWEEP: begin
                // Clear one live bit per cycle.
                o_live.we    = 1'b1;
                o_live.waddr = r_sweep;
                o_live.wdata = 1'b0;
                n_sweep      = r_sweep + sfla_pkg::SLOT_W'(1);
                if (r_sweep == LAST_SLOT) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_idx = i_in_req.slot_index;
                    case (i_in_req.op)
                        sfla_pkg::OP_ALLOC: begin
                            if (r_free_count == '0) begin
                                n_res = '{slot: '0, status: sfla_pkg::ST_EMPTY,
                                          high_water: r_top};
                                n_state = S_OUT;
                            end else begin
                                n_state = S_ALLOC;
                            end
                        end
                        sfla_pkg::OP_FREE: begin
                            n_state = S_FCHK;
                        end
                        sfla_pkg::OP_CLEAR: begin
                            n_free_count  = FULL_COUNT;
                            n_low         = FULL_COUNT;
                            n_top         = '0;
                            n_res         = '{slot: '0, status: sfla_pkg::ST_OK,
                                              high_water: '0};
                            n_after_sweep = 1'b1;
                            n_state       = S_OUT;
                        end
                        default: begin
                            n_res   = '{slot: '0, status: sfla_pkg::ST_OK,
                                        high_water: r_top};
                            n_state = S_OUT;
                        end
                    endcase
                end
            end
            S_ALLOC: begin
                // Stack data has arrived: mark the slot live and raise the mark.
                o_live.we    = 1'b1;
                o_live.waddr = w_pop_slot;
                o_live.wdata = 1'b1;
                n_free_count = r_free_count - sfla_pkg::CNT_W'(1);
                if (r_free_count == r_low) begin
                    n_low = r_free_count - sfla_pkg::CNT_W'(1);
                end
                if (w_slot_inc > r_top) begin
                    n_top = w_slot_inc;
                end
                n_res   = '{slot: w_pop_slot, status: sfla_pkg::ST_OK,
                            high_water: (w_slot_inc > r_top) ? w_slot_inc : r_top};
                n_state = S_OUT;
            end
            S_FCHK: begin
                if (!i_live_rdata) begin
                    n_res   = '{slot: '0, status: sfla_pkg::ST_NOT_LIVE,
                                high_water: r_top};
                    n_state = S_OUT;
                end else begin
                    // Kill the slot and push it back on the stack.
                    o_live.we    = 1'b1;
                    o_live.waddr = r_idx;
                    o_live.wdata = 1'b0;
                    if (r_free_count < FULL_COUNT) begin
                        o_stk.we     = 1'b1;
                        n_free_count = r_free_count + sfla_pkg::CNT_W'(1);
                    end
                    n_state = S_SCAN_RD;
                end
            end
            S_SCAN_RD: begin
                if (r_top == '0) begin
                    n_res   = '{slot: '0, status: sfla_pkg::ST_OK, high_water: '0};
                    n_state = S_OUT;
                end else begin
                    o_live.raddr = w_top_dec[sfla_pkg::SLOT_W-1:0];
                    n_state      = S_SCAN_CHK;
                end
            end
            S_SCAN_CHK: begin
                if (!i_live_rdata) begin
                    n_top   = w_top_dec;
                    n_state = S_SCAN_RD;
                end else begin
                    n_res   = '{slot: '0, status: sfla_pkg::ST_OK, high_water: r_top};
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                // Hand the response over once the output register has room.
                if (i_out_free) begin
                    o_load        = 1'b1;
                    n_after_sweep = 1'b0;
                    n_state       = r_after_sweep ? S_SWEEP : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_SWEEP;
            r_sweep       <= '0;
            r_free_count  <= FULL_COUNT;
            r_low         <= FULL_COUNT;
            r_top         <= '0;
            r_after_sweep <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_sweep       <= n_sweep;
            r_free_count  <= n_free_count;
            r_low         <= n_low;
            r_top         <= n_top;
            r_after_sweep <= n_after_sweep;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        r_res <= n_res;
    end

    assign o_in_stall        = (r_state != S_IDLE);
    assign o_res             = r_res;
    assign o_stat.free_count = r_free_count;
    assign o_stat.high_water = r_top;

endmodule

`default_nettype wire

@@ hdl/slot_free_list_allocator.sv @@
// ===========================================================================
// slot_free_list_allocator
// LIFO free-list allocator for a pool of 1024 slots with live map and
// high-water tracking.
// ===========================================================================
//
//   Channel   Direction   Handshake               Payload
//   request   in          i_in_valid/o_in_stall   i_in_req  (op, slot_index)
//   response  out         o_out_valid/i_out_stall o_out_rsp (slot, status, high_water)
//
// An allocate goes through stack read, live map update and response load. An
// empty allocate, an unused op and a clear go straight to the response load,
// and a clear is then followed by a live map pass over all 1024 slots. A dead
// free checks the live bit; a live free clears it, pushes the slot and walks the
// high-water mark down past trailing dead slots. After reset the same pass runs
// with request stall high; a stalled response holds the next one.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module slot_free_list_allocator (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    output logic                o_in_stall,
    input  wire sfla_pkg::t_req i_in_req,
    output logic                o_out_valid,
    input  wire logic           i_out_stall,
    output sfla_pkg::t_rsp      o_out_rsp
);

    localparam logic [sfla_pkg::CNT_W-1:0] POOL_SIZE = sfla_pkg::CNT_W'(sfla_pkg::SLOTS);

    logic                         w_out_free;
    logic                         w_load;
    sfla_pkg::t_rsp               w_res;
    sfla_pkg::t_stk_port          w_stk;
    sfla_pkg::t_live_port         w_live;
    sfla_pkg::t_ctrl_stat         w_stat;
    logic [sfla_pkg::SLOT_W-1:0]  w_stk_rdata;
    logic                         w_live_rdata;
    logic                         w_rsp_empty;
    logic                         w_in_range;

    logic                         r_out_valid;
    sfla_pkg::t_rsp               r_out_rsp;

    // Free stack of slot numbers.
    sfla_ram #(
        .WIDTH (sfla_pkg::SLOT_W),
        .DEPTH (sfla_pkg::SLOTS)
    ) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (w_stk.we),
        .i_waddr (w_stk.waddr),
        .i_wdata (w_stk.wdata),
        .i_raddr (w_stk.raddr),
        .o_rdata (w_stk_rdata)
    );

    // One live bit per slot.
    sfla_ram #(
        .WIDTH (1),
        .DEPTH (sfla_pkg::SLOTS)
    ) u_live_ram (
        .i_clk   (i_clk),
        .i_we    (w_live.we),
        .i_waddr (w_live.waddr),
        .i_wdata (w_live.wdata),
        .i_raddr (w_live.raddr),
        .o_rdata (w_live_rdata)
    );

    // Sequencer.
    sfla_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_in_req     (i_in_req),
        .i_out_free   (w_out_free),
        .o_load       (w_load),
        .o_res        (w_res),
        .o_stk        (w_stk),
        .i_stk_rdata  (w_stk_rdata),
        .o_live       (w_live),
        .i_live_rdata (w_live_rdata),
        .o_stat       (w_stat)
    );

    // Response register.
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_rsp <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

    // Conditions watched by the assertions below.
    assign w_rsp_empty = w_load && (w_res.status == sfla_pkg::ST_EMPTY);
    assign w_in_range  = (w_stat.free_count <= POOL_SIZE) && (w_stat.high_water <= POOL_SIZE);

    // A response must never overwrite one that is still stalled.
    `SFLA_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, w_load, w_out_free, "response overwritten")
    // An empty status is only reported when the stack really is empty.
    `SFLA_ASSERT_IMP(a_empty_real, i_clk, i_rst_n, w_rsp_empty, w_stat.free_count == '0, "false empty")
    // A push never runs past the top of the stack.
    `SFLA_ASSERT_IMP(a_push_room, i_clk, i_rst_n, w_stk.we, w_stat.free_count < POOL_SIZE, "push on full")
    // The free count and the high-water mark stay within the pool.
    `SFLA_ASSERT(a_bounds, i_clk, i_rst_n, w_in_range, "counter out of range")

endmodule

`default_nettype wire
